/* rtl/amseq_pkg.sv */
// Shared types, register indexes and reset values for the appliance mode sequencer.
package amseq_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int NOW_W          = 32;
	localparam int CFG_W          = 32;
	localparam int CNT_W          = 8;
	localparam int IDX_W          = 3;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_ATTRACT = 3'd1,
		MODE_FILLING = 3'd2,
		MODE_FILLED  = 3'd3,
		MODE_PETTING = 3'd4,
		MODE_SAD     = 3'd5,
		MODE_HAPPY   = 3'd6
	} mode_t;

	localparam logic [IDX_W-1:0] REG_ATTRACT_DURATION = 3'd0;
	localparam logic [IDX_W-1:0] REG_ATTRACT_DELAY    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SAD_DELAY        = 3'd2;
	localparam logic [IDX_W-1:0] REG_SAD_DURATION     = 3'd3;
	localparam logic [IDX_W-1:0] REG_HAPPY_DELAY      = 3'd4;
	localparam logic [IDX_W-1:0] REG_REFILL_THRESHOLD = 3'd5;
	localparam logic [IDX_W-1:0] REG_PETTING_DURATION = 3'd6;

	localparam logic [CFG_W-1:0] RST_ATTRACT_DURATION = 32'd30000;
	localparam logic [CFG_W-1:0] RST_ATTRACT_DELAY    = 32'd120000;
	localparam logic [CFG_W-1:0] RST_SAD_DELAY        = 32'd300000;
	localparam logic [CFG_W-1:0] RST_SAD_DURATION     = 32'd25000;
	localparam logic [CFG_W-1:0] RST_HAPPY_DELAY      = 32'd10000;
	localparam logic [CNT_W-1:0] RST_REFILL_THRESHOLD = 8'd10;
	localparam logic [CFG_W-1:0] RST_PETTING_DURATION = 32'd60000;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [CFG_W-1:0] attract_duration;
		logic [CFG_W-1:0] attract_delay;
		logic [CFG_W-1:0] sad_delay;
		logic [CFG_W-1:0] sad_duration;
		logic [CFG_W-1:0] happy_delay;
		logic [CNT_W-1:0] refill_threshold;
		logic [CFG_W-1:0] petting_duration;
	} cfg_t;

	typedef struct packed {
		logic bottle_present;
		logic pump_running;
		logic person_near;
		logic touch_active;
		logic servo_done;
		logic display_done;
	} flags_t;

	typedef struct packed {
		mode_t            mode;
		logic             mode_changed;
		logic             stop_pump;
		logic [CNT_W-1:0] refills;
	} result_t;

endpackage

/* rtl/amseq_step.sv */
// Transition rules of one poll: next mode, change flag, stop-pump flag and refill count.
module amseq_step import amseq_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  mode_t                 cur_mode,
	input  logic [TIME_WIDTH-1:0] entry_time,
	input  logic [CNT_W-1:0]      refill_count,
	input  cfg_t                  cfg,
	input  logic [TIME_WIDTH-1:0] now,
	input  flags_t                flags,
	output result_t               res
);

	localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	logic [TIME_WIDTH-1:0] elapsed;
	logic [CMP_W-1:0]      el;
	mode_t                 next_mode;
	logic                  stop;
	logic                  changed;

	// Elapsed time wraps with the timestamp width.
	assign elapsed = now - entry_time;
	assign el      = CMP_W'(elapsed);

	always_comb begin
		next_mode = cur_mode;
		stop      = 1'b0;
		unique case (cur_mode)
			MODE_IDLE: begin
				if (flags.bottle_present) next_mode = MODE_FILLING;
				else if (refill_count >= cfg.refill_threshold &&
					el > CMP_W'(cfg.happy_delay)) next_mode = MODE_HAPPY;
				else if (flags.person_near && el > CMP_W'(cfg.attract_delay))
					next_mode = MODE_ATTRACT;
				else if (flags.touch_active) next_mode = MODE_PETTING;
				else if (el > CMP_W'(cfg.sad_delay)) next_mode = MODE_SAD;
			end
			MODE_ATTRACT: begin
				if (flags.bottle_present) next_mode = MODE_FILLING;
				else if (flags.touch_active) next_mode = MODE_PETTING;
				else if (el > CMP_W'(cfg.attract_duration)) next_mode = MODE_IDLE;
			end
			MODE_FILLING: begin
				if (!flags.bottle_present && flags.pump_running) begin
					next_mode = MODE_FILLED;
					stop      = 1'b1;
				end else if (!flags.pump_running) begin
					next_mode = MODE_FILLED;
				end
			end
			MODE_FILLED: begin
				if (!flags.bottle_present) next_mode = MODE_IDLE;
			end
			MODE_PETTING: begin
				if (flags.bottle_present) next_mode = MODE_FILLING;
				else if (el > CMP_W'(cfg.petting_duration)) next_mode = MODE_IDLE;
			end
			MODE_SAD: begin
				if (flags.bottle_present) next_mode = MODE_FILLING;
				else if (flags.person_near) next_mode = MODE_ATTRACT;
				else if (el >= CMP_W'(cfg.sad_duration)) next_mode = MODE_IDLE;
			end
			MODE_HAPPY: begin
				if (flags.bottle_present) next_mode = MODE_FILLING;
				else if (flags.servo_done && flags.display_done) next_mode = MODE_IDLE;
			end
			default: begin
				next_mode = MODE_IDLE;
			end
		endcase
	end

	assign changed = (next_mode != cur_mode);

	always_comb begin
		res.mode         = next_mode;
		res.mode_changed = changed;
		res.stop_pump    = stop;
		res.refills      = refill_count;
		if (changed) begin
			if (next_mode == MODE_FILLED) begin
				if (refill_count != CNT_MAX) res.refills = refill_count + CNT_W'(1);
			end else if (next_mode == MODE_HAPPY || next_mode == MODE_SAD) begin
				res.refills = '0;
			end
		end
	end

endmodule

/* rtl/appliance_mode_sequencer.sv */
// Mode sequencer for a bottle-filling kiosk: input stage, rule logic and result stage.
//
// Usage: each poll beat on the input channel carries a millisecond timestamp and
// the sensor flags. Every poll produces exactly one result beat with the mode after
// the poll, a mode-change flag, a stop-pump flag and the refill count.
// The poll is captured in an input register; the transition rules are evaluated
// from that register and the mode state, and the result is captured in an output
// register while the state is updated in the same edge.
// A result beat passes the input register and then the result register; a stall
// of the receiver can hold it between them. Throughput is one poll per cycle while
// the receiver does not stall; the path that sets it is the combinational rule
// evaluation from the input register to the result register.
// When the receiver stalls, the result register holds its beat, the input
// register keeps the next poll, and in_ready drops once both are full.
// Configuration writes are taken every cycle (cfg_ready is always high); indexes
// beyond the register list are ignored. Write only while no poll is in flight.
// Reset puts the mode in idle, clears the entry time and refill count, loads
// the default register values and empties both stages.
module appliance_mode_sequencer import amseq_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NOW_W-1:0] now_ms,
	input  logic             bottle_present,
	input  logic             pump_running,
	input  logic             person_near,
	input  logic             touch_active,
	input  logic             servo_done,
	input  logic             display_done,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       mode,
	output logic             mode_changed,
	output logic             stop_pump,
	output logic [CNT_W-1:0] refills
);

	cfg_t                  cfg_q;
	mode_t                 mode_q;
	logic [TIME_WIDTH-1:0] entry_q;
	logic [CNT_W-1:0]      count_q;

	logic                  valid_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	flags_t                flags_s1;
	logic                  valid_s2;
	result_t               res_s2;

	result_t               step_res;
	logic                  advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attract_duration <= RST_ATTRACT_DURATION;
			cfg_q.attract_delay    <= RST_ATTRACT_DELAY;
			cfg_q.sad_delay        <= RST_SAD_DELAY;
			cfg_q.sad_duration     <= RST_SAD_DURATION;
			cfg_q.happy_delay      <= RST_HAPPY_DELAY;
			cfg_q.refill_threshold <= RST_REFILL_THRESHOLD;
			cfg_q.petting_duration <= RST_PETTING_DURATION;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ATTRACT_DURATION: cfg_q.attract_duration <= cfg_data;
				REG_ATTRACT_DELAY:    cfg_q.attract_delay    <= cfg_data;
				REG_SAD_DELAY:        cfg_q.sad_delay        <= cfg_data;
				REG_SAD_DURATION:     cfg_q.sad_duration     <= cfg_data;
				REG_HAPPY_DELAY:      cfg_q.happy_delay      <= cfg_data;
				REG_REFILL_THRESHOLD: cfg_q.refill_threshold <= cfg_data[CNT_W-1:0];
				REG_PETTING_DURATION: cfg_q.petting_duration <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	amseq_step #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_step (
		.cur_mode    (mode_q),
		.entry_time  (entry_q),
		.refill_count(count_q),
		.cfg         (cfg_q),
		.now         (now_s1),
		.flags       (flags_s1),
		.res         (step_res)
	);

	// Control: stage valids and the mode state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mode_q   <= MODE_IDLE;
			entry_q  <= '0;
			count_q  <= '0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;

			if (advance) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;

			if (advance) begin
				mode_q  <= step_res.mode;
				count_q <= step_res.refills;
				if (step_res.mode_changed) entry_q <= now_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1                  <= TIME_WIDTH'(now_ms);
			flags_s1.bottle_present <= bottle_present;
			flags_s1.pump_running   <= pump_running;
			flags_s1.person_near    <= person_near;
			flags_s1.touch_active   <= touch_active;
			flags_s1.servo_done     <= servo_done;
			flags_s1.display_done   <= display_done;
		end
		if (advance) res_s2 <= step_res;
	end

	assign out_valid    = valid_s2;
	assign mode         = res_s2.mode;
	assign mode_changed = res_s2.mode_changed;
	assign stop_pump    = res_s2.stop_pump;
	assign refills      = res_s2.refills;

	// A stop-pump beat always reports a fresh entry into filled.
	a_stop_enters_filled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop_pump |-> mode_changed && mode == MODE_FILLED)
		else $error("stop_pump without entry into filled");

	// Entering filled always leaves a nonzero refill count.
	a_filled_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_changed && mode == MODE_FILLED |-> refills != '0)
		else $error("refill count not advanced on entry into filled");

	// Entering happy or sad clears the refill count.
	a_reward_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_changed && (mode == MODE_HAPPY || mode == MODE_SAD)
		|-> refills == '0)
		else $error("refill count not cleared on entry into happy or sad");

	// The state registers track the mode and refill count of the last captured result beat.
	a_state_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> mode_q == res_s2.mode && count_q == res_s2.refills)
		else $error("mode state diverged from result");

	// The input stage can always take a beat while it is empty.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while empty");

endmodule

/* tb/tb_appliance_mode_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the appliance mode sequencer with its own mode predictor.
module tb_appliance_mode_sequencer;
	import amseq_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int LONG_HOLD    = 150;
	localparam int QUIET_CYCLES = 8;
	localparam int MAX_PRINTS   = 200;

	typedef struct packed {
		logic [NOW_W-1:0] now_ms;
		flags_t           sensors;
	} poll_t;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW} sink_style_t;
	typedef enum int {SC_FILL, SC_TOUCH, SC_PERSON, SC_WAIT, SC_CHEER, SC_NOISE} scene_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	poll_t            on_wire   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       mode;
	logic             mode_changed;
	logic             stop_pump;
	logic [CNT_W-1:0] refills;

	// Predictor state, kept in step with the block.
	cfg_t cfg_shadow = '{
		attract_duration: RST_ATTRACT_DURATION,
		attract_delay:    RST_ATTRACT_DELAY,
		sad_delay:        RST_SAD_DELAY,
		sad_duration:     RST_SAD_DURATION,
		happy_delay:      RST_HAPPY_DELAY,
		refill_threshold: RST_REFILL_THRESHOLD,
		petting_duration: RST_PETTING_DURATION
	};
	mode_t            kiosk_mode    = MODE_IDLE;
	logic [NOW_W-1:0] kiosk_entry   = '0;
	logic [CNT_W-1:0] kiosk_refills = '0;

	poll_t            pending_polls[$];
	result_t          expected_results[$];
	logic             poll_taken    = 1'b0;
	int               cfg_beats     = 0;
	int               mismatches    = 0;
	int               polls_queued  = 0;
	int               hold_requests = 0;
	int               hold_served   = 0;
	int               hold_left     = 0;
	int               sink_left     = 0;
	sink_style_t      sink_style    = SINK_OPEN;
	int               burst_left    = 0;
	int               gap_left      = 0;
	logic [NOW_W-1:0] wall_ms       = '0;

	appliance_mode_sequencer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.now_ms         (on_wire.now_ms),
		.bottle_present (on_wire.sensors.bottle_present),
		.pump_running   (on_wire.sensors.pump_running),
		.person_near    (on_wire.sensors.person_near),
		.touch_active   (on_wire.sensors.touch_active),
		.servo_done     (on_wire.sensors.servo_done),
		.display_done   (on_wire.sensors.display_done),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mode           (mode),
		.mode_changed   (mode_changed),
		.stop_pump      (stop_pump),
		.refills        (refills)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one poll to the predicted kiosk state and returns the result beat.
	function automatic result_t predict_poll_result(input poll_t p);
		logic [NOW_W-1:0] since;
		mode_t            nxt;
		result_t          r;
		since = p.now_ms - kiosk_entry;
		nxt = kiosk_mode;
		r.stop_pump = 1'b0;
		case (kiosk_mode)
			MODE_IDLE: begin
				if (p.sensors.bottle_present)
					nxt = MODE_FILLING;
				else if (kiosk_refills >= cfg_shadow.refill_threshold &&
						since > cfg_shadow.happy_delay)
					nxt = MODE_HAPPY;
				else if (p.sensors.person_near && since > cfg_shadow.attract_delay)
					nxt = MODE_ATTRACT;
				else if (p.sensors.touch_active)
					nxt = MODE_PETTING;
				else if (since > cfg_shadow.sad_delay)
					nxt = MODE_SAD;
			end
			MODE_ATTRACT: begin
				if (p.sensors.bottle_present)
					nxt = MODE_FILLING;
				else if (p.sensors.touch_active)
					nxt = MODE_PETTING;
				else if (since > cfg_shadow.attract_duration)
					nxt = MODE_IDLE;
			end
			MODE_FILLING: begin
				if (!p.sensors.bottle_present && p.sensors.pump_running) begin
					nxt = MODE_FILLED;
					r.stop_pump = 1'b1;
				end else if (!p.sensors.pump_running) begin
					nxt = MODE_FILLED;
				end
			end
			MODE_FILLED: begin
				if (!p.sensors.bottle_present)
					nxt = MODE_IDLE;
			end
			MODE_PETTING: begin
				if (p.sensors.bottle_present)
					nxt = MODE_FILLING;
				else if (since > cfg_shadow.petting_duration)
					nxt = MODE_IDLE;
			end
			MODE_SAD: begin
				if (p.sensors.bottle_present)
					nxt = MODE_FILLING;
				else if (p.sensors.person_near)
					nxt = MODE_ATTRACT;
				else if (since >= cfg_shadow.sad_duration)
					nxt = MODE_IDLE;
			end
			MODE_HAPPY: begin
				if (p.sensors.bottle_present)
					nxt = MODE_FILLING;
				else if (p.sensors.servo_done && p.sensors.display_done)
					nxt = MODE_IDLE;
			end
			default: nxt = MODE_IDLE;
		endcase
		r.mode_changed = (nxt != kiosk_mode);
		if (nxt != kiosk_mode) begin
			kiosk_mode = nxt;
			kiosk_entry = p.now_ms;
			if (nxt == MODE_FILLED) begin
				if (kiosk_refills != CNT_MAX)
					kiosk_refills++;
			end else if (nxt == MODE_HAPPY || nxt == MODE_SAD) begin
				kiosk_refills = '0;
			end
		end
		r.mode = kiosk_mode;
		r.refills = kiosk_refills;
		return r;
	endfunction

	// Handshake monitor: tracks register writes, predicts accepted polls, checks results.
	always @(posedge clk) begin
		result_t want;
		poll_taken = in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATTRACT_DURATION: cfg_shadow.attract_duration = cfg_data;
					REG_ATTRACT_DELAY:    cfg_shadow.attract_delay = cfg_data;
					REG_SAD_DELAY:        cfg_shadow.sad_delay = cfg_data;
					REG_SAD_DURATION:     cfg_shadow.sad_duration = cfg_data;
					REG_HAPPY_DELAY:      cfg_shadow.happy_delay = cfg_data;
					REG_REFILL_THRESHOLD: cfg_shadow.refill_threshold = cfg_data[CNT_W-1:0];
					REG_PETTING_DURATION: cfg_shadow.petting_duration = cfg_data;
					default: ;
				endcase
				cfg_beats++;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result beat with no poll pending (mode %0d)", mode));
				end else begin
					want = expected_results.pop_front();
					if (mode !== want.mode)
						report_mismatch($sformatf("mode %0h, want %0d", mode, want.mode));
					if (mode_changed !== want.mode_changed)
						report_mismatch($sformatf("mode_changed %0h, want %0h",
							mode_changed, want.mode_changed));
					if (stop_pump !== want.stop_pump)
						report_mismatch($sformatf("stop_pump %0h, want %0h",
							stop_pump, want.stop_pump));
					if (refills !== want.refills)
						report_mismatch($sformatf("refills %0h, want %0d",
							refills, want.refills));
				end
			end
			if (poll_taken)
				expected_results.push_back(predict_poll_result(on_wire));
		end
	end

	// Poll driver: bursts of beats separated by random gaps.
	always @(negedge clk) begin
		poll_t p;
		if (!in_valid || poll_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_polls.size() > 0) begin
				p = pending_polls.pop_front();
				on_wire <= p;
				in_valid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: its own stall pattern, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (sink_left == 0) begin
				sink_style = sink_style_t'($urandom_range(0, 2));
				sink_left = $urandom_range(4, 40);
			end
			sink_left--;
			case (sink_style)
				SINK_OPEN: out_ready <= 1'b1;
				SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
				default:   out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic flags_t flags_of(input bit bottle, input bit pump, input bit person,
			input bit touch, input bit servo, input bit disp);
		return '{bottle, pump, person, touch, servo, disp};
	endfunction

	function automatic flags_t random_flags();
		logic [5:0] b;
		b = 6'($urandom_range(0, 63));
		return flags_t'(b);
	endfunction

	task automatic push_poll(input logic [NOW_W-1:0] t, input flags_t f);
		pending_polls.push_back('{now_ms: t, sensors: f});
		polls_queued++;
	endtask

	task automatic queue_tick(input flags_t f, input int unsigned step_max);
		wall_ms += $urandom_range(0, step_max);
		push_poll(wall_ms, f);
	endtask

	function automatic scene_t pick_scene();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return SC_FILL;
		if (r < 45)
			return SC_TOUCH;
		if (r < 57)
			return SC_PERSON;
		if (r < 80)
			return SC_WAIT;
		if (r < 90)
			return SC_CHEER;
		return SC_NOISE;
	endfunction

	// Queues a short, mostly well-formed sequence of polls with random extra flags.
	task automatic add_scenario(input scene_t kind, input int unsigned step_max);
		flags_t      f;
		int unsigned n;
		case (kind)
			SC_FILL: begin
				f = random_flags();
				f.bottle_present = 1'b1;
				f.pump_running = 1'b1;
				queue_tick(f, step_max);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				repeat (n) begin
					f = random_flags();
					f.bottle_present = 1'b1;
					f.pump_running = 1'b1;
					queue_tick(f, step_max);
				end
				// Either the bottle is pulled mid-fill or the pump finishes.
				f = random_flags();
				if ($urandom_range(0, 1)) begin
					f.bottle_present = 1'b0;
					f.pump_running = 1'b1;
				end else begin
					f.pump_running = 1'b0;
				end
				queue_tick(f, step_max);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
				repeat (n) begin
					f = random_flags();
					f.bottle_present = 1'b1;
					queue_tick(f, step_max);
				end
				f = random_flags();
				f.bottle_present = 1'b0;
				queue_tick(f, step_max);
			end
			SC_TOUCH: begin
				f = random_flags();
				f.bottle_present = 1'b0;
				f.touch_active = 1'b1;
				queue_tick(f, step_max);
			end
			SC_PERSON: begin
				f = random_flags();
				f.bottle_present = 1'b0;
				f.person_near = 1'b1;
				queue_tick(f, step_max);
			end
			SC_WAIT: begin
				repeat ($urandom_range(1, 4)) begin
					f = random_flags();
					f.bottle_present = 1'b0;
					f.person_near = 1'b0;
					f.touch_active = 1'b0;
					queue_tick(f, step_max);
				end
			end
			SC_CHEER: begin
				f = random_flags();
				f.bottle_present = 1'b0;
				f.servo_done = 1'b1;
				f.display_done = 1'b1;
				queue_tick(f, step_max);
			end
			default: begin
				if ($urandom_range(0, 3) == 0)
					wall_ms = $urandom();
				queue_tick(random_flags(), step_max);
			end
		endcase
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		int seen;
		@(negedge clk);
		seen = cfg_beats;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (cfg_beats == seen);
		cfg_valid <= 1'b0;
	endtask

	// The threshold goes out with junk in the upper bits, and the unused index is hit too.
	task automatic load_config(input cfg_t c);
		logic [CFG_W-1:0] junk;
		junk = $urandom();
		write_reg(REG_UNUSED, $urandom());
		write_reg(REG_PETTING_DURATION, c.petting_duration);
		write_reg(REG_REFILL_THRESHOLD, {junk[CFG_W-1:CNT_W], c.refill_threshold});
		write_reg(REG_HAPPY_DELAY, c.happy_delay);
		write_reg(REG_SAD_DURATION, c.sad_duration);
		write_reg(REG_SAD_DELAY, c.sad_delay);
		write_reg(REG_ATTRACT_DELAY, c.attract_delay);
		write_reg(REG_ATTRACT_DURATION, c.attract_duration);
	endtask

	// Waits until every poll has been taken and every result has come back.
	task automatic drain();
		while (pending_polls.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cfg_t   c;
		flags_t f;
		int     stop_at;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the rules at their boundaries with the reset register values.
		push_poll(32'd0,       flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd5,       flags_of(0, 0, 0, 1, 0, 0));
		push_poll(32'd60005,   flags_of(0, 1, 1, 0, 1, 1));
		push_poll(32'd60006,   flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd180006,  flags_of(0, 0, 1, 0, 0, 0));
		push_poll(32'd180007,  flags_of(0, 0, 1, 0, 0, 0));
		push_poll(32'd210007,  flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd210008,  flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd510008,  flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd510009,  flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd535008,  flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd535009,  flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'd835010,  flags_of(0, 1, 0, 0, 1, 1));
		push_poll(32'd835011,  flags_of(0, 0, 1, 0, 0, 0));
		push_poll(32'd835012,  flags_of(0, 0, 0, 1, 0, 0));
		// Fill across the timestamp wrap, with the bottle pulled while pumping.
		push_poll(32'hFFFF_FFF0, flags_of(1, 1, 0, 0, 0, 0));
		push_poll(32'hFFFF_FFFF, flags_of(1, 1, 1, 1, 1, 1));
		push_poll(32'h0000_0010, flags_of(0, 1, 0, 0, 0, 0));
		push_poll(32'h0000_0020, flags_of(1, 0, 0, 0, 0, 0));
		push_poll(32'h0000_0030, flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'h0000_0040, flags_of(1, 1, 0, 0, 0, 0));
		push_poll(32'h0000_0050, flags_of(1, 0, 0, 0, 0, 0));
		push_poll(32'h0000_0060, flags_of(0, 0, 0, 0, 0, 0));
		push_poll(32'h0000_0070, flags_of(0, 0, 1, 1, 0, 0));
		push_poll(32'h0000_0080, flags_of(1, 0, 0, 0, 0, 0));
		drain();

		// Short timeouts, so every mode is reached often; the clock wraps early on.
		c.attract_duration = $urandom_range(0, 300);
		c.attract_delay = $urandom_range(0, 300);
		c.sad_delay = $urandom_range(200, 600);
		c.sad_duration = $urandom_range(0, 300);
		c.happy_delay = $urandom_range(0, 200);
		c.refill_threshold = CNT_W'($urandom_range(1, 4));
		c.petting_duration = $urandom_range(0, 300);
		load_config(c);
		wall_ms = 32'hFFFF_F000 + $urandom_range(0, 255);
		stop_at = polls_queued + 60;
		while (polls_queued < stop_at)
			add_scenario(pick_scene(), 120);
		hold_requests++;
		drain();

		// All-ones registers: happy and sad are out of reach, so the counter saturates.
		c = '1;
		c.attract_delay = '0;
		load_config(c);
		repeat (258) begin
			if ($urandom_range(0, 19) == 0)
				add_scenario(scene_t'($urandom_range(SC_TOUCH, SC_WAIT)), 1000);
			// A lean fill: start, then finish or pull the bottle, then leave.
			f = random_flags();
			f.bottle_present = 1'b1;
			f.pump_running = 1'b1;
			queue_tick(f, 1000);
			f = random_flags();
			if ($urandom_range(0, 1)) begin
				f.bottle_present = 1'b0;
				f.pump_running = 1'b1;
			end else begin
				f.pump_running = 1'b0;
			end
			queue_tick(f, 1000);
			f = random_flags();
			f.bottle_present = 1'b0;
			queue_tick(f, 1000);
		end
		drain();

		// All-zero registers: every timeout fires as soon as the clock moves.
		c = '0;
		load_config(c);
		wall_ms = $urandom();
		stop_at = polls_queued + 40;
		while (polls_queued < stop_at)
			add_scenario(pick_scene(), 5);
		drain();

		repeat (QUIET_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
